@@ rtl/solar_equatorial_position_defines.svh @@
// Assertion macros shared by the solar position RTL.
`ifndef SOLAR_EQUATORIAL_POSITION_DEFINES_SVH
`define SOLAR_EQUATORIAL_POSITION_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define SEP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sep: same-cycle check failed");

// Next-cycle implication, checked on clk and disabled during reset.
`define SEP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sep: next-cycle check failed");

`endif

@@ rtl/sep_pkg.sv @@
// Package: widths, almanac constants and the CORDIC arctangent table.
package sep_pkg;

    localparam int DAY_W            = 33;
    localparam int OUT_W            = 32;
    localparam int ANGLE_BITS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 24;

    // Binary fraction floor(num / den * 2^64), long-hand restoring form.
    function automatic logic [63:0] frac64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] r;
        logic [63:0] q;
        r = num;
        q = '0;
        for (int k = 0; k < 64; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // Integer quotient by shift and subtract, for elaboration-time tables.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int k = 63; k >= 0; k--)
        begin
            r = {r[62:0], num[k]};
            if (r >= den)
            begin
                r    = r - den;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    localparam logic [63:0] INV_2PI  = frac64(64'd159154943091895336, 64'd1000000000000000000);
    localparam logic [63:0] INV_GAIN = frac64(64'd607252935008881256, 64'd1000000000000000000);
    localparam logic [63:0] L_BASE   = frac64(64'd280460, 64'd360000);
    localparam logic [63:0] L_RATE   = frac64(64'd9856474, 64'd3600000000);
    localparam logic [63:0] G_BASE   = frac64(64'd357528, 64'd360000);
    localparam logic [63:0] G_RATE   = frac64(64'd9856003, 64'd3600000000);
    localparam logic [63:0] E_BASE   = frac64(64'd23439, 64'd360000);
    localparam logic [63:0] E_RATE   = frac64(64'd4, 64'd3600000000);
    localparam logic [63:0] EOC1     = frac64(64'd1915, 64'd360000);
    localparam logic [63:0] EOC2     = frac64(64'd20, 64'd360000);

    // Micro-rotation angle of step i at 2^abits per turn. Step zero is an eighth of a turn;
    // the others come from the arctangent series in radians, scaled by 1/(2 pi).
    function automatic logic [63:0] atan_entry(input int i, input int abits);
        logic signed [63:0]  s;
        logic [63:0]         term;
        logic signed [129:0] p;
        int                  e;
        s = '0;
        if (i == 0)
        begin
            return 64'd1 << (abits - 3);
        end
        for (int k = 0; k < 32; k++)
        begin
            e = (2 * k + 1) * i;
            if (e <= 62)
            begin
                term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
                if (k % 2 == 1)
                begin
                    s = s - $signed(term);
                end
                else
                begin
                    s = s + $signed(term);
                end
            end
        end
        p = 130'(s) * $signed({66'd0, INV_2PI});
        p = p >>> (126 - abits);
        return p[63:0];
    endfunction

endpackage

@@ rtl/sep_ifs.sv @@
// Request channels: time samples in, sky positions out.
interface sep_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sep_pkg::DAY_W-1:0]      day_number;

    modport source (output valid, output day_number, input ready);
    modport sink   (input valid, input day_number, output ready);
endinterface

interface sep_result_if;
    logic                                  valid;
    logic                                  ready;
    logic        [sep_pkg::OUT_W-1:0]      right_ascension;
    logic signed [sep_pkg::OUT_W-1:0]      declination;

    modport source (output valid, output right_ascension, output declination, input ready);
    modport sink   (input valid, input right_ascension, input declination, output ready);
endinterface

@@ rtl/solar_equatorial_position.sv @@
// Top level: pipelined solar right ascension and declination from a day number.
//
//   channel  direction  fields
//   sample   in         day_number (33b signed, 1/65536 day since J2000)
//   result   out        right_ascension (32b turns), declination (32b signed turns)
//
// One sample enters per cycle while the pipeline is not stalled; the latency is set by
// four CORDIC chains in series plus ten stages for products, sums and the output register.
// The whole pipeline advances together; it stalls only while a result waits unread.
// Reset clears the valid bits only; the data registers hold no state between samples.
`include "solar_equatorial_position_defines.svh"

module solar_equatorial_position #(
    parameter int ANGLE_BITS   = sep_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = sep_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    sep_sample_if.sink          sample,
    sep_result_if.source        result
);

    localparam int A     = ANGLE_BITS;
    localparam int F     = ANGLE_BITS - 2;
    localparam int W     = ANGLE_BITS + 2;
    localparam int C     = CORDIC_STEPS + 1;
    localparam int DEPTH = 4 * C + 10;

    localparam logic [63:0] StartFull = sep_pkg::INV_GAIN >> (66 - ANGLE_BITS);
    localparam logic signed [W-1:0] Start = W'(StartFull);

    localparam logic signed [32:0] LRateHi = {1'b0, sep_pkg::L_RATE[63:32]};
    localparam logic signed [32:0] LRateLo = {1'b0, sep_pkg::L_RATE[31:0]};
    localparam logic signed [32:0] GRateHi = {1'b0, sep_pkg::G_RATE[63:32]};
    localparam logic signed [32:0] GRateLo = {1'b0, sep_pkg::G_RATE[31:0]};
    localparam logic signed [32:0] ERateHi = {1'b0, sep_pkg::E_RATE[63:32]};
    localparam logic signed [32:0] ERateLo = {1'b0, sep_pkg::E_RATE[31:0]};
    localparam logic signed [32:0] Eoc1Hi  = {1'b0, sep_pkg::EOC1[63:32]};
    localparam logic signed [32:0] Eoc1Lo  = {1'b0, sep_pkg::EOC1[31:0]};
    localparam logic signed [32:0] Eoc2Hi  = {1'b0, sep_pkg::EOC2[63:32]};
    localparam logic signed [32:0] Eoc2Lo  = {1'b0, sep_pkg::EOC2[31:0]};
    localparam logic signed [32:0] GainHi  = {1'b0, sep_pkg::INV_GAIN[63:32]};
    localparam logic signed [32:0] GainLo  = {1'b0, sep_pkg::INV_GAIN[31:0]};

    logic             adv;
    logic             in_fire;
    logic [DEPTH:1]   vld_reg;
    logic [DEPTH:1]   vld_next;

    // Global advance: the pipeline moves whenever the output slot is free or being read.
    assign adv          = !vld_reg[DEPTH] || result.ready;
    assign sample.ready = adv;
    assign in_fire      = sample.valid && adv;
    assign vld_next     = {vld_reg[DEPTH-1:1], in_fire};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Time products: the 64-bit rates are split into halves for 33 x 33 multipliers.
    logic signed [32:0] n_reg;
    logic signed [65:0] lp_hi_reg, lp_lo_reg, gp_hi_reg, gp_lo_reg, ep_hi_reg, ep_lo_reg;
    logic signed [97:0] lf, gf, ef;
    logic [63:0]        l64_reg, g64_reg, e64_reg;

    assign lf = (98'(lp_hi_reg) <<< 32) + 98'(lp_lo_reg);
    assign gf = (98'(gp_hi_reg) <<< 32) + 98'(gp_lo_reg);
    assign ef = (98'(ep_hi_reg) <<< 32) + 98'(ep_lo_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg     <= sample.day_number;
            lp_hi_reg <= n_reg * LRateHi;
            lp_lo_reg <= n_reg * LRateLo;
            gp_hi_reg <= n_reg * GRateHi;
            gp_lo_reg <= n_reg * GRateLo;
            ep_hi_reg <= n_reg * ERateHi;
            ep_lo_reg <= n_reg * ERateLo;
            l64_reg   <= sep_pkg::L_BASE + lf[79:16];
            g64_reg   <= sep_pkg::G_BASE + gf[79:16];
            e64_reg   <= sep_pkg::E_BASE - ef[79:16];
        end
    end

    // Sine of the mean anomaly and of twice it.
    logic [A-1:0]        g_a;
    logic [A-1:0]        g2_a;
    logic signed [W-1:0] sg, s2;

    assign g_a  = g64_reg[63 -: A];
    assign g2_a = g_a << 1;

    sep_cordic #(.ANGLE_BITS(A), .CORDIC_STEPS(CORDIC_STEPS), .VECTORING(1'b0)) u_rot_g (
        .clk(clk), .en(adv), .x_in(Start), .y_in('0), .z_in(g_a),
        .x_out(), .y_out(sg), .z_out()
    );

    sep_cordic #(.ANGLE_BITS(A), .CORDIC_STEPS(CORDIC_STEPS), .VECTORING(1'b0)) u_rot_g2 (
        .clk(clk), .en(adv), .x_in(Start), .y_in('0), .z_in(g2_a),
        .x_out(), .y_out(s2), .z_out()
    );

    // Mean longitude and obliquity wait alongside the anomaly chain.
    logic [63:0]  l64_dly_reg [0:C+1];
    logic [A-1:0] eps_dly_reg [0:C+2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l64_dly_reg[0] <= l64_reg;
            eps_dly_reg[0] <= e64_reg[63 -: A];
            for (int j = 1; j <= C + 1; j++)
            begin
                l64_dly_reg[j] <= l64_dly_reg[j-1];
            end
            for (int j = 1; j <= C + 2; j++)
            begin
                eps_dly_reg[j] <= eps_dly_reg[j-1];
            end
        end
    end

    // Equation of centre: products, then shift, then sum into the ecliptic longitude.
    logic signed [W+32:0] c1_hi_reg, c1_lo_reg, c2_hi_reg, c2_lo_reg;
    logic signed [W+64:0] c1f, c2f;
    logic [63:0]          t1_reg, t2_reg;
    logic [63:0]          lam_sum;
    logic [A-1:0]         lam_reg;

    assign c1f     = ((W+65)'(c1_hi_reg) <<< 32) + (W+65)'(c1_lo_reg);
    assign c2f     = ((W+65)'(c2_hi_reg) <<< 32) + (W+65)'(c2_lo_reg);
    assign lam_sum = l64_dly_reg[C+1] + t1_reg + t2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_hi_reg <= sg * Eoc1Hi;
            c1_lo_reg <= sg * Eoc1Lo;
            c2_hi_reg <= s2 * Eoc2Hi;
            c2_lo_reg <= s2 * Eoc2Lo;
            t1_reg    <= c1f[F+63:F];
            t2_reg    <= c2f[F+63:F];
            lam_reg   <= lam_sum[63 -: A];
        end
    end

    // Sine and cosine of the ecliptic longitude and of the obliquity.
    logic signed [W-1:0] cl, sl, ce, se;

    sep_cordic #(.ANGLE_BITS(A), .CORDIC_STEPS(CORDIC_STEPS), .VECTORING(1'b0)) u_rot_lam (
        .clk(clk), .en(adv), .x_in(Start), .y_in('0), .z_in(lam_reg),
        .x_out(cl), .y_out(sl), .z_out()
    );

    sep_cordic #(.ANGLE_BITS(A), .CORDIC_STEPS(CORDIC_STEPS), .VECTORING(1'b0)) u_rot_eps (
        .clk(clk), .en(adv), .x_in(Start), .y_in('0), .z_in(eps_dly_reg[C+2]),
        .x_out(ce), .y_out(se), .z_out()
    );

    // Tilt onto the equator: y = sin(lambda) cos(eps), z = sin(lambda) sin(eps).
    logic signed [W-1:0]   ce_c, se_c;
    logic signed [2*W-1:0] yp, zp;
    logic signed [W-1:0]   y_reg, z_reg, cl_reg;

    assign ce_c = ce[W-1] ? '0 : ce;
    assign se_c = se[W-1] ? '0 : se;
    assign yp   = sl * ce_c;
    assign zp   = sl * se_c;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y_reg  <= yp[F+W-1:F];
            z_reg  <= zp[F+W-1:F];
            cl_reg <= cl;
        end
    end

    // Right ascension and the projected radius.
    logic signed [W-1:0] r;
    logic [A-1:0]        ra_a;

    sep_cordic #(.ANGLE_BITS(A), .CORDIC_STEPS(CORDIC_STEPS), .VECTORING(1'b1)) u_vec_ra (
        .clk(clk), .en(adv), .x_in(cl_reg), .y_in(y_reg), .z_in('0),
        .x_out(r), .y_out(), .z_out(ra_a)
    );

    // Remove the CORDIC gain from the radius; z and RA wait meanwhile.
    logic signed [W-1:0]  z_dly_reg  [0:C+1];
    logic [A-1:0]         ra_dly_reg [0:C+1];
    logic signed [W+32:0] rp_hi_reg, rp_lo_reg;
    logic signed [W+64:0] rf;
    logic signed [W-1:0]  rr_reg;

    assign rf = ((W+65)'(rp_hi_reg) <<< 32) + (W+65)'(rp_lo_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rp_hi_reg     <= r * GainHi;
            rp_lo_reg     <= r * GainLo;
            rr_reg        <= rf[W+63:64];
            z_dly_reg[0]  <= z_reg;
            ra_dly_reg[0] <= ra_a;
            for (int j = 1; j <= C + 1; j++)
            begin
                z_dly_reg[j]  <= z_dly_reg[j-1];
                ra_dly_reg[j] <= ra_dly_reg[j-1];
            end
        end
    end

    // Declination as the angle of (radius, z).
    logic [A-1:0] dec_a;

    sep_cordic #(.ANGLE_BITS(A), .CORDIC_STEPS(CORDIC_STEPS), .VECTORING(1'b1)) u_vec_dec (
        .clk(clk), .en(adv), .x_in(rr_reg), .y_in(z_dly_reg[C+1]), .z_in('0),
        .x_out(), .y_out(), .z_out(dec_a)
    );

    // Scale both angles to 32 bits per turn and register the result.
    logic [sep_pkg::OUT_W-1:0] ra_fmt, dec_fmt;

    if (ANGLE_BITS >= sep_pkg::OUT_W)
    begin : g_narrow
        assign ra_fmt  = ra_dly_reg[C+1][A-1 -: sep_pkg::OUT_W];
        assign dec_fmt = dec_a[A-1 -: sep_pkg::OUT_W];
    end
    else
    begin : g_widen
        assign ra_fmt  = {ra_dly_reg[C+1], {(sep_pkg::OUT_W - A){1'b0}}};
        assign dec_fmt = {dec_a, {(sep_pkg::OUT_W - A){1'b0}}};
    end

    logic [sep_pkg::OUT_W-1:0]        ra_out_reg;
    logic signed [sep_pkg::OUT_W-1:0] dec_out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ra_out_reg  <= ra_fmt;
            dec_out_reg <= $signed(dec_fmt);
        end
    end

    assign result.valid           = vld_reg[DEPTH];
    assign result.right_ascension = ra_out_reg;
    assign result.declination     = dec_out_reg;

    // Checks on the pipeline control and on the result range.
    `SEP_ASSERT_NEXT(a_enter_pipe, sample.valid && sample.ready, vld_reg[1])
    `SEP_ASSERT_NEXT(a_stall_holds, result.valid && !result.ready, $stable(vld_reg))
    `SEP_ASSERT_IMPL(a_dec_range, result.valid,
        (result.declination <= 32'sd1073741824) && (result.declination >= -32'sd1073741824))

endmodule

@@ rtl/sep_cordic.sv @@
// Pipelined CORDIC, one register stage per micro-rotation, rotation or vectoring mode.
module sep_cordic #(
    parameter int ANGLE_BITS   = sep_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = sep_pkg::CORDIC_STEPS_DEF,
    parameter bit VECTORING    = 1'b0
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [ANGLE_BITS+1:0] x_in,
    input  logic signed [ANGLE_BITS+1:0] y_in,
    input  logic        [ANGLE_BITS-1:0] z_in,
    output logic signed [ANGLE_BITS+1:0] x_out,
    output logic signed [ANGLE_BITS+1:0] y_out,
    output logic        [ANGLE_BITS-1:0] z_out
);

    localparam int W  = ANGLE_BITS + 2;
    localparam int ZW = ANGLE_BITS + 1;
    localparam logic [ANGLE_BITS-1:0] Half    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] Quarter = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic signed [W-1:0]  x_reg [0:CORDIC_STEPS];
    logic signed [W-1:0]  y_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STEPS];

    logic                  flip;
    logic [ANGLE_BITS-1:0] quad_sum;
    logic [ANGLE_BITS-1:0] turned;
    logic signed [W-1:0]   x0_next;
    logic signed [W-1:0]   y0_next;
    logic signed [ZW-1:0]  z0_next;

    // Fold the start into the right half plane so that the iterations converge.
    always_comb
    begin
        quad_sum = z_in + Quarter;
        turned   = z_in + Half;
        if (VECTORING)
        begin
            flip    = x_in[W-1];
            z0_next = flip ? ZW'(Half) : '0;
        end
        else
        begin
            flip    = quad_sum[ANGLE_BITS-1];
            z0_next = flip ? ZW'($signed(turned)) : ZW'($signed(z_in));
        end
        x0_next = flip ? -x_in : x_in;
        y0_next = flip ? -y_in : y_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            z_reg[0] <= z0_next;
        end
    end

    // One micro-rotation per stage; the direction comes from the angle or from y.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [ZW-1:0] Step = ZW'(sep_pkg::atan_entry(i, ANGLE_BITS));
        logic                pos;
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;

        assign pos = VECTORING ? y_reg[i][W-1] : !z_reg[i][ZW-1];
        assign xs  = x_reg[i] >>> i;
        assign ys  = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1] <= pos ? x_reg[i] - ys : x_reg[i] + ys;
                y_reg[i+1] <= pos ? y_reg[i] + xs : y_reg[i] - xs;
                z_reg[i+1] <= pos ? z_reg[i] - Step : z_reg[i] + Step;
            end
        end
    end

    assign x_out = x_reg[CORDIC_STEPS];
    assign y_out = y_reg[CORDIC_STEPS];
    assign z_out = z_reg[CORDIC_STEPS][ANGLE_BITS-1:0];

endmodule

@@ bench/tb.sv @@
// Testbench for the solar right ascension and declination pipeline.
`timescale 1ns / 100ps

module tb;

    localparam int  AB        = 32;
    localparam int  STEPS     = 24;
    localparam int  FRAC      = AB - 2;
    localparam int  LATENCY   = 4 * (STEPS + 1) + 10;
    localparam int  N_RANDOM  = 1330;
    localparam int  LIMIT     = 400000;
    localparam logic [63:0] AMASK = (64'd1 << AB) - 64'd1;
    localparam logic [63:0] AHALF = 64'd1 << (AB - 1);
    localparam logic [63:0] AQTR  = 64'd1 << (AB - 2);

    typedef struct packed {
        logic [31:0]        ra;
        logic signed [31:0] dec;
    } sky_pos_t;

    logic clk;
    logic rst_n;
    int   cycle_count;
    bit   long_hold_req;
    bit   long_hold_done;

    logic [63:0] step_angle [STEPS];

    sep_sample_if smp();
    sep_result_if res();

    solar_equatorial_position uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res)
    );

    // Floor of a * c / 2^sh, kept modulo 2^64.
    function automatic logic [63:0] mul_floor(input logic signed [63:0] a,
                                              input logic [63:0] c, input int sh);
        logic signed [129:0] p;
        p = $signed({{66{a[63]}}, a}) * $signed({66'd0, c});
        p = p >>> sh;
        return p[63:0];
    endfunction

    function automatic longint angle_signed(input logic [63:0] v);
        logic [63:0] m;
        m = v & AMASK;
        if (m & AHALF)
        begin
            return longint'(m) - longint'(64'd1 << AB);
        end
        return longint'(m);
    endfunction

    // Micro-rotation angles: an eighth of a turn first, then a truncated arctangent series.
    task automatic build_angles();
        longint s;
        int     e;
        step_angle[0] = 64'd1 << (AB - 3);
        for (int i = 1; i < STEPS; i++)
        begin
            s = 0;
            for (int k = 0; (2 * k + 1) * i <= 62; k++)
            begin
                e = (2 * k + 1) * i;
                if (k % 2 == 1)
                    s = s - longint'((64'd1 << (62 - e)) / (2 * k + 1));
                else
                    s = s + longint'((64'd1 << (62 - e)) / (2 * k + 1));
            end
            step_angle[i] = mul_floor(s, sep_pkg::INV_2PI, 126 - AB);
        end
    endtask

    // Rotation mode: cosine and sine of an angle, scaled by the start magnitude.
    function automatic void cordic_rotate(input longint x0, input logic [63:0] ang,
                                          output longint xo, output longint yo);
        logic [63:0] a;
        longint      x, y, z, nx;
        a = ang & AMASK;
        if (((a + AQTR) & AMASK) >= AHALF)
        begin
            x0 = -x0;
            a  = (a + AHALF) & AMASK;
        end
        x = x0;
        y = 0;
        z = angle_signed(a);
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(step_angle[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(step_angle[i]);
            end
            x = nx;
        end
        xo = x;
        yo = y;
    endfunction

    // Vectoring mode: angle and scaled magnitude of (x, y).
    function automatic void cordic_vector(input longint xi, input longint yi,
                                          output logic [63:0] ang, output longint mag);
        longint      x, y, nx;
        logic [63:0] z;
        x = xi;
        y = yi;
        z = 64'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = AHALF;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + step_angle[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - step_angle[i];
            end
            x = nx;
        end
        ang = z & AMASK;
        mag = x;
    endfunction

    // Almanac position for one day number.
    function automatic sky_pos_t solar_position(input logic signed [32:0] day);
        longint      n, start, cg, sg, c2, s2, cl, sl, ce, se, y, z, r, rr, dm;
        logic [63:0] l64, g64, e64, g, lam, eps, ra, dec;
        sky_pos_t    p;
        n     = longint'(day);
        start = longint'(sep_pkg::INV_GAIN >> (64 - FRAC));
        l64   = sep_pkg::L_BASE + mul_floor(n, sep_pkg::L_RATE, 16);
        g64   = sep_pkg::G_BASE + mul_floor(n, sep_pkg::G_RATE, 16);
        e64   = sep_pkg::E_BASE - mul_floor(n, sep_pkg::E_RATE, 16);
        g     = g64 >> (64 - AB);
        cordic_rotate(start, g, cg, sg);
        cordic_rotate(start, (g << 1) & AMASK, c2, s2);
        l64 = l64 + mul_floor(sg, sep_pkg::EOC1, FRAC) + mul_floor(s2, sep_pkg::EOC2, FRAC);
        lam = l64 >> (64 - AB);
        eps = e64 >> (64 - AB);
        cordic_rotate(start, lam, cl, sl);
        cordic_rotate(start, eps, ce, se);
        if (ce < 0) ce = 0;
        if (se < 0) se = 0;
        y = longint'(mul_floor(sl, ce, FRAC));
        z = longint'(mul_floor(sl, se, FRAC));
        cordic_vector(cl, y, ra, r);
        rr = longint'(mul_floor(r, sep_pkg::INV_GAIN, 64));
        cordic_vector(rr, z, dec, dm);
        p.ra  = ra[31:0];
        p.dec = 32'(angle_signed(dec));
        return p;
    endfunction

    // Expected positions in order of acceptance, and the mismatch tally.
    class position_board;
        sky_pos_t pending_pos [$];
        int       errors;

        function void note_sample(logic signed [32:0] day);
            pending_pos.push_back(solar_position(day));
        endfunction

        function void check_result(logic [31:0] ra, logic signed [31:0] dec);
            sky_pos_t want;
            if (pending_pos.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: ra %h dec %h", ra, dec);
                return;
            end
            want = pending_pos.pop_front();
            if (want.ra !== ra || want.dec !== dec)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: ra exp %h got %h, dec exp %h got %h",
                             want.ra, ra, want.dec, dec);
            end
        endfunction
    endclass

    position_board board = new();

    // Clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_day(input logic signed [32:0] day, input bit may_idle);
        int gap;
        smp.valid      <= 1'b1;
        smp.day_number <= day;
        do @(negedge clk); while (!smp.ready);
        board.note_sample(day);
        @(posedge clk);
        gap = may_idle ? gap_len() : 0;
        if (gap > 0)
        begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [32:0] random_day();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return {$urandom_range(0, 1) == 1, 32'($urandom)};
        if (r < 85)
            return 33'(signed'($urandom_range(0, 2 * 36525 * 256))
                       - 36525 * 256) * 33'sd256 + 33'($urandom_range(0, 255));
        return 33'($urandom_range(0, 65535)) - 33'sd32768;
    endfunction

    // Result side: random stalls, and one long hold-off on request.
    initial
    begin
        int hold;
        long_hold_done = 1'b0;
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done && hold == 0)
            begin
                hold           = 400;
                long_hold_done = 1'b1;
            end
            if (hold > 0)
            begin
                hold--;
                res.ready <= 1'b0;
            end
            else if (cycle_count % 2000 < 500)
                res.ready <= 1'b1;
            else
                res.ready <= (gap_len() == 0);
        end
    end

    // Result check, sampled away from the active edge.
    always @(negedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            board.check_result(res.right_ascension, res.declination);
    end

    // Stimulus and end of run.
    initial
    begin
        logic signed [32:0] corner [] = '{33'sd0, 33'sd1, -33'sd1, 33'sh0FFFFFFFF,
            -33'sh100000000, 33'sd65536, -33'sd65536, 33'sd5832000, 33'sd5439488,
            33'sd12009472, 33'sd17979392, 33'sd23978803, 33'sd2393661440,
            -33'sd2393661440, 33'sh0AAAAAAAA, 33'sh155555555, 33'sh080000000,
            -33'sh080000000, 33'sd32768, 33'sd65535};
        int wait_cycles;
        rst_n          = 1'b0;
        long_hold_req  = 1'b0;
        build_angles();
        smp.valid      <= 1'b0;
        smp.day_number <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Epoch, range ends, one day either side and equinox and solstice times.
        foreach (corner[i])
            send_day(corner[i], i > 10);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 400)
                long_hold_req = 1'b1;
            if (i == 800)
            begin
                smp.valid <= 1'b0;
                while (board.pending_pos.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            send_day(random_day(), (i / 200) % 3 != 1);
        end
        smp.valid <= 1'b0;

        wait_cycles = 0;
        while (board.pending_pos.size() != 0 && wait_cycles < 50000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (board.errors == 0 && board.pending_pos.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ solar_equatorial_position.f @@
+incdir+rtl
rtl/sep_pkg.sv
rtl/sep_ifs.sv
rtl/sep_cordic.sv
rtl/solar_equatorial_position.sv
bench/tb.sv
